// ===== rtl/mpc_pkg.sv =====
package mpc_pkg;

   localparam int COUNT_BITS_DEF = 20;
   localparam int SAMPLE_W       = 16;
   localparam int CORR_W         = 32;
   localparam int PAIR_W         = 21;
   localparam int Q_W            = 32;
   localparam int ROOT_STEPS     = 2 * Q_W;
   localparam int STEP_W         = $clog2(ROOT_STEPS);
   localparam int FRAC_SHIFT     = 62;

   localparam logic [SAMPLE_W-1:0] MASK_RESET = 16'h7FFF;
   localparam logic [CORR_W-1:0]   ONE_Q30    = 32'h4000_0000;

   typedef enum logic [2:0] {
      ST_ACC,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_LOAD,
      ST_OUT
   } state_type;

   // order of the shared multiplier jobs
   typedef enum logic [2:0] {
      OP_N_SAB,
      OP_SA_SB,
      OP_N_SAA,
      OP_SA_SA,
      OP_N_SBB,
      OP_SB_SB,
      OP_NUM_SQ,
      OP_PROD
   } op_type;

   typedef struct packed {
      logic   acc_en;
      logic   clear;
      logic   mul_start;
      op_type op;
      logic   wb;
      logic   root_init;
      logic   root_step;
      logic   root_phase;
      logic   load_result;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
   } status_type;

endpackage

// ===== rtl/mpc_mul.sv =====
module mpc_mul import mpc_pkg::*; #(
   parameter int W = 73
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [W-1:0]   a,
   input  logic signed [W-1:0]   b,
   output logic                  done,
   output logic signed [2*W-1:0] product
);

   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2*W-1:0]   mcand_ff, mcand_in;
   logic [W-1:0]     mplier_ff, mplier_in;
   logic [2*W-1:0]   acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [W-1:0]     mag_a, mag_b;

   assign mag_a = a[W-1] ? W'(-a) : W'(a);
   assign mag_b = b[W-1] ? W'(-b) : W'(b);

   // shift and add, one multiplier bit a cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mcand_in  = (2*W)'(mag_a);
         mplier_in = mag_b;
         acc_in    = '0;
         neg_in    = a[W-1] ^ b[W-1];
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
   end

   assign done    = done_ff;
   assign product = neg_ff ? $signed(-acc_ff) : $signed(acc_ff);

endmodule

// ===== rtl/mpc_ctrl.sv =====
module mpc_ctrl import mpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_item,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_ACC: begin
            if (req_valid && req_last_item) begin
               state_in = ST_MUL_GO;
               op_in    = OP_N_SAB;
            end
         end
         ST_MUL_GO: begin
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (status.mul_done) begin
               if (op_ff == OP_PROD) begin
                  state_in = ST_ROOT_INIT;
               end else begin
                  op_in    = op_type'(op_ff + 3'd1);
                  state_in = ST_MUL_GO;
               end
            end
         end
         ST_ROOT_INIT: begin
            step_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.op         = op_ff;
      cmd.root_phase = step_ff[0];
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         ST_ACC: begin
            req_ready  = 1'b1;
            cmd.acc_en = req_valid;
         end
         ST_MUL_GO:    cmd.mul_start = 1'b1;
         ST_MUL_WAIT:  cmd.wb = status.mul_done;
         ST_ROOT_INIT: cmd.root_init = 1'b1;
         ST_ROOT:      cmd.root_step = 1'b1;
         ST_LOAD:      cmd.load_result = 1'b1;
         ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         op_ff    <= OP_N_SAB;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides open together");
   a_back_to_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("no return to accumulation after result word");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == ST_MUL_WAIT))
      else $error("multiplier finished outside wait state");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> !status.mul_done)
      else $error("multiplier done too early");
`endif

endmodule

// ===== rtl/mpc_datapath.sv =====
module mpc_datapath import mpc_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  logic signed [SAMPLE_W-1:0] first_sample,
   input  logic signed [SAMPLE_W-1:0] second_sample,
   input  logic                       csr_wr_en,
   input  logic [SAMPLE_W-1:0]        csr_wr_data,
   output logic signed [CORR_W-1:0]   correlation,
   output logic [PAIR_W-1:0]          pair_count,
   output logic                       undefined_flag
);

   localparam int CNT_W = COUNT_BITS + 1;
   localparam int SUM_W = COUNT_BITS + 17;
   localparam int SQ_W  = COUNT_BITS + 33;
   localparam int VW    = 2 * COUNT_BITS + 33;
   localparam int PW    = 2 * VW;
   localparam int RW    = PW + FRAC_SHIFT + 4;

   logic [SAMPLE_W-1:0]     mask_ff, mask_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sa_ff, sa_in, sb_ff, sb_in;
   logic signed [SQ_W-1:0]  saa_ff, saa_in, sbb_ff, sbb_in, sab_ff, sab_in;
   logic signed [VW-1:0]    p0_ff, p0_in, num_ff, num_in, va_ff, va_in, vb_ff, vb_in;
   logic [PW-1:0]           n2_ff, n2_in, pw_ff, pw_in;
   logic [RW-1:0]           s_ff, s_in, e_ff, e_in, d_ff, d_in, cand_ff, cand_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic signed [CORR_W-1:0] corr_ff, corr_in;
   logic [PAIR_W-1:0]       pc_ff, pc_in;
   logic                    undef_ff, undef_in;

   logic                    keep;
   logic signed [31:0]      prod_aa, prod_bb, prod_ab;
   logic signed [VW-1:0]    mul_a, mul_b, low_p;
   logic signed [PW-1:0]    mul_p;
   logic [RW:0]             diff;
   logic [Q_W:0]            rnd_sum;
   logic [Q_W-1:0]          rnd, mag;
   logic                    undef_now;

   assign keep = (first_sample != mask_ff) && (second_sample != mask_ff)
               && !count_ff[COUNT_BITS];
   assign prod_aa = first_sample * first_sample;
   assign prod_bb = second_sample * second_sample;
   assign prod_ab = first_sample * second_sample;

   always_comb begin
      mask_in  = csr_wr_en ? csr_wr_data : mask_ff;
      count_in = count_ff;
      sa_in    = sa_ff;
      sb_in    = sb_ff;
      saa_in   = saa_ff;
      sbb_in   = sbb_ff;
      sab_in   = sab_ff;
      if (cmd.clear) begin
         count_in = '0;
         sa_in    = '0;
         sb_in    = '0;
         saa_in   = '0;
         sbb_in   = '0;
         sab_in   = '0;
      end else if (cmd.acc_en && keep) begin
         count_in = count_ff + CNT_W'(1);
         sa_in    = sa_ff + SUM_W'(first_sample);
         sb_in    = sb_ff + SUM_W'(second_sample);
         saa_in   = saa_ff + SQ_W'(prod_aa);
         sbb_in   = sbb_ff + SQ_W'(prod_bb);
         sab_in   = sab_ff + SQ_W'(prod_ab);
      end
   end

   always_comb begin
      mul_a = VW'($signed({1'b0, count_ff}));
      mul_b = VW'(sab_ff);
      unique case (cmd.op)
         OP_N_SAB:  begin mul_a = VW'($signed({1'b0, count_ff})); mul_b = VW'(sab_ff); end
         OP_SA_SB:  begin mul_a = VW'(sa_ff); mul_b = VW'(sb_ff); end
         OP_N_SAA:  begin mul_a = VW'($signed({1'b0, count_ff})); mul_b = VW'(saa_ff); end
         OP_SA_SA:  begin mul_a = VW'(sa_ff); mul_b = VW'(sa_ff); end
         OP_N_SBB:  begin mul_a = VW'($signed({1'b0, count_ff})); mul_b = VW'(sbb_ff); end
         OP_SB_SB:  begin mul_a = VW'(sb_ff); mul_b = VW'(sb_ff); end
         OP_NUM_SQ: begin mul_a = num_ff; mul_b = num_ff; end
         OP_PROD:   begin mul_a = va_ff; mul_b = vb_ff; end
         default:   begin mul_a = num_ff; mul_b = num_ff; end
      endcase
   end

   mpc_mul #(.W(VW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (status.mul_done),
      .product (mul_p)
   );

   assign low_p = $signed(mul_p[VW-1:0]);

   always_comb begin
      p0_in  = p0_ff;
      num_in = num_ff;
      va_in  = va_ff;
      vb_in  = vb_ff;
      n2_in  = n2_ff;
      pw_in  = pw_ff;
      if (cmd.wb) begin
         unique case (cmd.op)
            OP_N_SAB, OP_N_SAA, OP_N_SBB: p0_in = low_p;
            OP_SA_SB:  num_in = p0_ff - low_p;
            OP_SA_SA:  va_in  = p0_ff - low_p;
            OP_SB_SB:  vb_in  = p0_ff - low_p;
            OP_NUM_SQ: n2_in  = mul_p;
            OP_PROD:   pw_in  = mul_p;
            default:   p0_in  = p0_ff;
         endcase
      end
   end

   // bit-wise root search, slack s = 2^62 num^2 - q^2 P, e = 2^(b+1) q P, d = 2^(2b) P
   assign diff = {1'b0, s_ff} - {1'b0, cand_ff};

   always_comb begin
      s_in    = s_ff;
      e_in    = e_ff;
      d_in    = d_ff;
      cand_in = cand_ff;
      q_in    = q_ff;
      if (cmd.root_init) begin
         s_in = RW'({n2_ff, {FRAC_SHIFT{1'b0}}});
         d_in = RW'({pw_ff, {FRAC_SHIFT{1'b0}}});
         e_in = '0;
         q_in = '0;
      end else if (cmd.root_step) begin
         if (!cmd.root_phase) begin
            cand_in = e_ff + d_ff;
         end else begin
            d_in = d_ff >> 2;
            if (!diff[RW]) begin
               s_in = diff[RW-1:0];
               e_in = (e_ff >> 1) + d_ff;
               q_in = {q_ff[Q_W-2:0], 1'b1};
            end else begin
               e_in = e_ff >> 1;
               q_in = {q_ff[Q_W-2:0], 1'b0};
            end
         end
      end
   end

   assign rnd_sum   = {1'b0, q_ff} + (Q_W+1)'(1);
   assign rnd       = rnd_sum[Q_W:1];
   assign mag       = (rnd > ONE_Q30) ? ONE_Q30 : rnd;
   assign undef_now = (count_ff == '0) || (va_ff == '0) || va_ff[VW-1]
                    || (vb_ff == '0) || vb_ff[VW-1];

   always_comb begin
      corr_in  = corr_ff;
      pc_in    = pc_ff;
      undef_in = undef_ff;
      if (cmd.load_result) begin
         pc_in    = PAIR_W'({{PAIR_W{1'b0}}, count_ff});
         undef_in = undef_now;
         if (undef_now) begin
            corr_in = '0;
         end else begin
            corr_in = num_ff[VW-1] ? $signed(-mag) : $signed(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= MASK_RESET;
         count_ff <= '0;
         sa_ff    <= '0;
         sb_ff    <= '0;
         saa_ff   <= '0;
         sbb_ff   <= '0;
         sab_ff   <= '0;
      end else begin
         mask_ff  <= mask_in;
         count_ff <= count_in;
         sa_ff    <= sa_in;
         sb_ff    <= sb_in;
         saa_ff   <= saa_in;
         sbb_ff   <= sbb_in;
         sab_ff   <= sab_in;
      end
      p0_ff    <= p0_in;
      num_ff   <= num_in;
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      n2_ff    <= n2_in;
      pw_ff    <= pw_in;
      s_ff     <= s_in;
      e_ff     <= e_in;
      d_ff     <= d_in;
      cand_ff  <= cand_in;
      q_ff     <= q_in;
      corr_ff  <= corr_in;
      pc_ff    <= pc_in;
      undef_ff <= undef_in;
   end

   assign correlation    = corr_ff;
   assign pair_count     = pc_ff;
   assign undefined_flag = undef_ff;

endmodule

// ===== rtl/masked_pearson_correlation_core.sv =====
// accumulation: one voxel pair word per cycle while no result is pending
// last word: its result word is computed by eight jobs on one bit-serial multiplier
// and a bit-wise root search
// no input word is taken from the last word until its result word is taken
// reset (synchronous, active high) clears the sums and count, mask value to 32767
module masked_pearson_correlation_core import mpc_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_first_sample,
   input  logic signed [SAMPLE_W-1:0] req_second_sample,
   input  logic                       req_last_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [CORR_W-1:0]   rsp_correlation,
   output logic [PAIR_W-1:0]          rsp_pair_count,
   output logic                       rsp_undefined_flag,
   input  logic                       csr_wr_en,
   input  logic [SAMPLE_W-1:0]        csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   mpc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   mpc_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .first_sample   (req_first_sample),
      .second_sample  (req_second_sample),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .correlation    (rsp_correlation),
      .pair_count     (rsp_pair_count),
      .undefined_flag (rsp_undefined_flag)
   );

endmodule
